// ----- rtl/core/trrs_pkg.sv -----
// Shared definitions for the transmit ring round-robin scheduler.
// Holds default sizes, field widths, opcode and grant kind codes, the sequencer
// state type and the grant record. No dependencies.
package trrs_pkg;

    localparam int RING_SLOTS_DEF = 12;
    localparam int CHANNELS_DEF   = 8;

    // Fixed widths of the request and grant fields
    localparam int OP_W         = 2;
    localparam int CHAN_FIELD_W = 3;
    localparam int BLK_W        = 4;
    localparam int SLOT_FIELD_W = 4;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_STAGE    = 2'd0;
    localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;
    localparam logic [OP_W-1:0] OP_ENABLE   = 2'd2;

    // Grant kinds
    localparam logic KIND_SETUP  = 1'b0;
    localparam logic KIND_PACKET = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic                    kind;
        logic [CHAN_FIELD_W-1:0] chan;
        logic [BLK_W-1:0]        blocks;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [SLOT_FIELD_W-1:0] free;
    } t_grant;

endpackage

// ----- rtl/core/trrs_ring_math.sv -----
// Ring occupancy arithmetic for the transmit ring scheduler.
// Derives slots in use and free slots, and the wrapped write and reclaim positions.
// Depends on trrs_pkg.
module trrs_ring_math #(
    parameter int  RING_SLOTS = trrs_pkg::RING_SLOTS_DEF,
    localparam int SW         = $clog2(RING_SLOTS)
) (
    input  logic [SW-1:0]               i_write_slot,
    input  logic [SW-1:0]               i_reclaim_slot,
    input  logic [trrs_pkg::BLK_W-1:0]  i_grant_blocks,
    input  logic [trrs_pkg::BLK_W-1:0]  i_done_blocks,
    output logic [SW-1:0]               o_in_use,
    output logic [SW-1:0]               o_free,
    output logic [SW-1:0]               o_write_next,
    output logic [SW-1:0]               o_reclaim_next
);
    import trrs_pkg::*;

    localparam int WW = (SW > BLK_W) ? SW : BLK_W;
    localparam int AW = WW + 1;
    localparam logic [AW-1:0] RS = AW'(RING_SLOTS);

    logic [AW-1:0] w_x, r_x, g_x, d_x;
    logic [AW-1:0] used, free, freed, wsum, rsum;

    assign w_x = AW'(i_write_slot);
    assign r_x = AW'(i_reclaim_slot);
    assign g_x = AW'(i_grant_blocks);
    assign d_x = AW'(i_done_blocks);

    always_comb begin
        used = (w_x >= r_x) ? (w_x - r_x) : (w_x + RS - r_x);
        // One slot always stays empty so that a full ring differs from an empty one.
        free  = RS - AW'(1) - used;
        freed = (d_x < used) ? d_x : used;
        wsum  = w_x + g_x;
        if (wsum >= RS) begin
            wsum = wsum - RS;
        end
        rsum = r_x + freed;
        if (rsum >= RS) begin
            rsum = rsum - RS;
        end
    end

    assign o_in_use       = used[SW-1:0];
    assign o_free         = free[SW-1:0];
    assign o_write_next   = wsum[SW-1:0];
    assign o_reclaim_next = rsum[SW-1:0];

endmodule

// ----- rtl/core/tx_ring_round_robin_scheduler_unit.sv -----
// Top level of the transmit ring round-robin scheduler.
// Holds the request handshake, the grant sequencer, the staged packet table
// and the output register. Depends on trrs_pkg and trrs_ring_math.
//
// Usage:
//   The slave stream carries one request per transfer: tuser holds the opcode
//   (stage a packet, transmit completion, enable), tdata the channel and block
//   count. The master stream returns one grant per transfer: tuser is the grant
//   kind (setup or packet), tdata the channel, block count, first slot and the
//   free slots left, and tlast marks the final grant caused by a request.
//   A request that causes no grant returns nothing.
//   Ready is high only while the sequencer is idle. After a request, the
//   sequencer tests one channel per cycle against the free count with a single
//   shared compare, and pauses on a found grant that cannot yet be placed; a
//   setup grant needs no search.
//   A grant is held back one step so that tlast can be set on the final one;
//   the final grant leaves the hold stage once the search has ended.
//   Reset clears the ring positions, the staged flags, the last served channel
//   and the pending setup flag. When the receiver stalls, one grant waits in the
//   output register and one in the hold stage, and the sequencer pauses until
//   the output register is taken. Ready may return while the last grant waits.
module tx_ring_round_robin_scheduler_unit #(
    parameter int RING_SLOTS = trrs_pkg::RING_SLOTS_DEF,
    parameter int CHANNELS   = trrs_pkg::CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // channel[2:0], block_count[6:3], zero[7]
    input  logic [1:0]  i_s_axis_tuser,   // op[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // granted_channel[2:0], granted_blocks[6:3],
                                          // first_slot[10:7], free_after[14:11], zero[15]
    output logic [0:0]  o_m_axis_tuser,   // grant_kind[0]
    output logic        o_m_axis_tlast
);
    import trrs_pkg::*;

    localparam int SW  = $clog2(RING_SLOTS);
    localparam int CW  = $clog2(CHANNELS);
    localparam int WW  = (SW > BLK_W) ? SW : BLK_W;
    localparam int AW  = WW + 1;
    localparam int CXW = ((CW > CHAN_FIELD_W) ? CW : CHAN_FIELD_W) + 1;

    t_state r_state, n_state;

    logic [SW-1:0]    r_write_slot, r_reclaim_slot;
    logic [CW-1:0]    r_last_served;
    logic             r_setup_pending;
    logic [BLK_W-1:0] r_staged [CHANNELS];
    logic [CHANNELS-1:0] r_busy;
    logic [CW-1:0]    r_scan_idx, r_scan_cnt;

    t_grant r_hold, r_out, new_grant;
    logic   r_hold_vld, r_out_vld, r_out_last;

    // Request fields
    logic [OP_W-1:0]         in_op;
    logic [CHAN_FIELD_W-1:0] in_chan;
    logic [BLK_W-1:0]        in_cnt;
    logic [CXW-1:0]          chan_x;
    logic                    chan_ok;
    logic [CW-1:0]           chan_idx;
    logic                    accept;

    // Ring arithmetic
    logic [BLK_W-1:0] grant_blocks;
    logic [SW-1:0]    ring_in_use, ring_free, write_next, reclaim_next;
    logic [AW-1:0]    free_x, slot_x, free_after_x;
    logic [CXW-1:0]   idx_x;

    // Sequencer strobes
    logic do_setup, do_pkt, scan_start, scan_step, do_flush;
    logic hit, scan_last, out_free, can_place;

    function automatic logic [CW-1:0] next_chan(input logic [CW-1:0] c);
        next_chan = (c == CW'(CHANNELS - 1)) ? '0 : c + CW'(1);
    endfunction

    assign in_op    = i_s_axis_tuser;
    assign in_chan  = i_s_axis_tdata[2:0];
    assign in_cnt   = i_s_axis_tdata[6:3];
    assign chan_x   = CXW'(in_chan);
    assign chan_ok  = (chan_x < CXW'(CHANNELS));
    assign chan_idx = chan_x[CW-1:0];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign grant_blocks = r_setup_pending ? BLK_W'(1) : r_staged[r_scan_idx];

    trrs_ring_math #(
        .RING_SLOTS (RING_SLOTS)
    ) u_ring (
        .i_write_slot   (r_write_slot),
        .i_reclaim_slot (r_reclaim_slot),
        .i_grant_blocks (grant_blocks),
        .i_done_blocks  (in_cnt),
        .o_in_use       (ring_in_use),
        .o_free         (ring_free),
        .o_write_next   (write_next),
        .o_reclaim_next (reclaim_next)
    );

    assign free_x       = AW'(ring_free);
    assign slot_x       = AW'(r_write_slot);
    assign free_after_x = free_x - AW'(grant_blocks);
    assign idx_x        = CXW'(r_scan_idx);

    // The shared compare: one staged channel against the free count per cycle, held while a hit waits.
    assign hit       = r_busy[r_scan_idx] && (AW'(r_staged[r_scan_idx]) <= free_x);
    assign scan_last = (r_scan_cnt == CW'(CHANNELS - 1));
    assign out_free  = !r_out_vld || i_m_axis_tready;
    assign can_place = !r_hold_vld || out_free;

    always_comb begin
        new_grant.kind   = r_setup_pending ? KIND_SETUP : KIND_PACKET;
        new_grant.chan   = r_setup_pending ? '0 : idx_x[CHAN_FIELD_W-1:0];
        new_grant.blocks = grant_blocks;
        new_grant.slot   = slot_x[SLOT_FIELD_W-1:0];
        new_grant.free   = free_after_x[SLOT_FIELD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        do_setup   = 1'b0;
        do_pkt     = 1'b0;
        scan_start = 1'b0;
        scan_step  = 1'b0;
        do_flush   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_op inside {OP_STAGE, OP_COMPLETE, OP_ENABLE}) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                if (r_setup_pending) begin
                    if (ring_free == '0) begin
                        n_state = S_FLUSH;
                    end else if (can_place) begin
                        do_setup = 1'b1;
                    end
                end else begin
                    scan_start = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    if (can_place) begin
                        do_pkt  = 1'b1;
                        n_state = S_DECIDE;
                    end
                end else if (scan_last) begin
                    n_state = S_FLUSH;
                end else begin
                    scan_step = 1'b1;
                end
            end
            S_FLUSH: begin
                if (!r_hold_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    do_flush = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Ring positions, staged table and round-robin pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_slot    <= '0;
            r_reclaim_slot  <= '0;
            r_busy          <= '0;
            r_last_served   <= '0;
            r_setup_pending <= 1'b0;
        end else begin
            if (accept) begin
                if (in_op == OP_STAGE) begin
                    if (chan_ok && !r_busy[chan_idx] && in_cnt != '0) begin
                        r_busy[chan_idx] <= 1'b1;
                    end
                end else if (in_op == OP_COMPLETE) begin
                    r_reclaim_slot <= reclaim_next;
                end else if (in_op == OP_ENABLE) begin
                    r_write_slot    <= '0;
                    r_reclaim_slot  <= '0;
                    r_busy          <= '0;
                    r_last_served   <= '0;
                    r_setup_pending <= 1'b1;
                end
            end
            if (do_setup) begin
                r_setup_pending <= 1'b0;
                r_write_slot    <= write_next;
            end
            if (do_pkt) begin
                r_busy[r_scan_idx] <= 1'b0;
                r_last_served      <= r_scan_idx;
                r_write_slot       <= write_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && in_op == OP_STAGE && chan_ok && !r_busy[chan_idx]) begin
            r_staged[chan_idx] <= in_cnt;
        end
        if (scan_start) begin
            r_scan_idx <= next_chan(r_last_served);
            r_scan_cnt <= '0;
        end else if (scan_step) begin
            r_scan_idx <= next_chan(r_scan_idx);
            r_scan_cnt <= r_scan_cnt + CW'(1);
        end
    end

    // Hold stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (do_flush || ((do_setup || do_pkt) && r_hold_vld)) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (do_flush) begin
                r_hold_vld <= 1'b0;
            end else if (do_setup || do_pkt) begin
                r_hold_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((do_setup || do_pkt) && r_hold_vld) begin
            r_out      <= r_hold;
            r_out_last <= 1'b0;
        end else if (do_flush) begin
            r_out      <= r_hold;
            r_out_last <= 1'b1;
        end
        if (do_setup || do_pkt) begin
            r_hold <= new_grant;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {1'b0, r_out.free, r_out.slot, r_out.blocks, r_out.chan};
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out_last;

    // A new request is only taken once every grant of the previous one has left the hold stage.
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !r_hold_vld)
        else $error("request taken with a grant still held");

    a_ring_positions: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AW'(r_write_slot) < AW'(RING_SLOTS)) && (AW'(r_reclaim_slot) < AW'(RING_SLOTS))
        && (AW'(ring_in_use) < AW'(RING_SLOTS)))
        else $error("ring position out of range");

    a_granted_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pkt |=> !r_busy[$past(r_scan_idx)] && (r_last_served == $past(r_scan_idx)))
        else $error("granted channel still staged");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for tx_ring_round_robin_scheduler_unit.
// Predicts every grant from its own scheduler model and checks the master stream.
// Depends on trrs_pkg and the scheduler RTL only.
`timescale 1ns / 100ps

module testbench;

    import trrs_pkg::*;

    localparam int RING  = RING_SLOTS_DEF;
    localparam int CHANS = CHANNELS_DEF;

    // Opcode that the block does not define; it must be ignored.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 2 * (CHANS + 3);

    typedef enum {
        RX_STREAM,
        RX_RANDOM,
        RX_PERIODIC
    } t_rx_mode;

    typedef struct packed {
        t_grant grant;
        logic   last;
    } t_grant_rec;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = '0;    // channel[2:0], block_count[6:3], zero[7]
    logic [1:0]  i_s_axis_tuser  = '0;    // op[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;          // granted_channel[2:0], granted_blocks[6:3],
                                          // first_slot[10:7], free_after[14:11], zero[15]
    logic [0:0]  o_m_axis_tuser;          // grant_kind[0]
    logic        o_m_axis_tlast;

    // Scheduler model state
    logic [SLOT_FIELD_W-1:0] mdl_wr_slot;
    logic [SLOT_FIELD_W-1:0] mdl_rc_slot;
    logic [BLK_W-1:0]        mdl_staged [CHANS];
    logic [CHAN_FIELD_W-1:0] mdl_last;
    logic                    mdl_setup;

    t_grant_rec pending_grants [$];
    t_grant_rec want_grant;

    int err_cnt     = 0;
    int cycle_cnt   = 0;
    int rx_hold_len = 0;

    t_rx_mode rx_mode      = RX_STREAM;
    int       rx_mode_left = 0;
    int       rx_phase     = 0;

    tx_ring_round_robin_scheduler_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic int ring_in_use();
        if (mdl_wr_slot >= mdl_rc_slot)
            return int'(mdl_wr_slot) - int'(mdl_rc_slot);
        return RING - (int'(mdl_rc_slot) - int'(mdl_wr_slot));
    endfunction

    function automatic int ring_free();
        return RING - ring_in_use() - 1;
    endfunction

    function automatic void clear_model();
        mdl_wr_slot = '0;
        mdl_rc_slot = '0;
        foreach (mdl_staged[i])
            mdl_staged[i] = '0;
        mdl_last  = '0;
        mdl_setup = 1'b0;
    endfunction

    // Applies one accepted request to the model and queues the grants it causes.
    // A grant is queued one step late so that the final one can carry last.
    function automatic void schedule_request(logic [1:0] op, logic [2:0] chan,
                                             logic [3:0] cnt);
        int         n;
        int         used;
        int         free_now;
        int         idx;
        int         k;
        bit         found;
        bit         have_prev;
        t_grant_rec prev;
        t_grant_rec rec;

        n         = 0;
        have_prev = 1'b0;
        prev      = '0;
        idx       = 0;
        case (op)
            OP_STAGE: begin
                if (int'(chan) < CHANS && mdl_staged[chan] == '0)
                    mdl_staged[chan] = cnt;
            end
            OP_COMPLETE: begin
                used = ring_in_use();
                mdl_rc_slot = SLOT_FIELD_W'((int'(mdl_rc_slot)
                              + ((int'(cnt) < used) ? int'(cnt) : used)) % RING);
            end
            OP_ENABLE: begin
                clear_model();
                mdl_setup = 1'b1;
            end
            default: return;
        endcase

        while (n < CHANS + 1) begin
            rec = '0;
            if (mdl_setup) begin
                if (ring_free() < 1)
                    break;
                mdl_setup         = 1'b0;
                rec.grant.kind    = KIND_SETUP;
                rec.grant.chan    = '0;
                rec.grant.blocks  = 4'd1;
                rec.grant.slot    = mdl_wr_slot;
                rec.grant.free    = SLOT_FIELD_W'(ring_free() - 1);
                mdl_wr_slot       = SLOT_FIELD_W'((int'(mdl_wr_slot) + 1) % RING);
            end else begin
                free_now = ring_free();
                found    = 1'b0;
                for (k = 1; k <= CHANS && !found; k++) begin
                    idx = (int'(mdl_last) + k) % CHANS;
                    if (mdl_staged[idx] != '0 && int'(mdl_staged[idx]) <= free_now)
                        found = 1'b1;
                end
                if (!found)
                    break;
                rec.grant.kind   = KIND_PACKET;
                rec.grant.chan   = CHAN_FIELD_W'(idx);
                rec.grant.blocks = mdl_staged[idx];
                rec.grant.slot   = mdl_wr_slot;
                rec.grant.free   = SLOT_FIELD_W'(free_now - int'(mdl_staged[idx]));
                mdl_last         = CHAN_FIELD_W'(idx);
                mdl_wr_slot      = SLOT_FIELD_W'((int'(mdl_wr_slot)
                                   + int'(mdl_staged[idx])) % RING);
                mdl_staged[idx]  = '0;
            end
            if (have_prev)
                pending_grants.push_back(prev);
            prev      = rec;
            have_prev = 1'b1;
            n++;
        end
        if (have_prev) begin
            prev.last = 1'b1;
            pending_grants.push_back(prev);
        end
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    // Grant checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_grants.size() == 0) begin
                $error("grant: expected none, got channel %0d blocks %0d",
                       o_m_axis_tdata[2:0], o_m_axis_tdata[6:3]);
                err_cnt++;
            end else begin
                want_grant = pending_grants.pop_front();
                check_field("grant_kind", int'(want_grant.grant.kind),
                            int'(o_m_axis_tuser[0]));
                check_field("granted_channel", int'(want_grant.grant.chan),
                            int'(o_m_axis_tdata[2:0]));
                check_field("granted_blocks", int'(want_grant.grant.blocks),
                            int'(o_m_axis_tdata[6:3]));
                check_field("first_slot", int'(want_grant.grant.slot),
                            int'(o_m_axis_tdata[10:7]));
                check_field("free_after", int'(want_grant.grant.free),
                            int'(o_m_axis_tdata[14:11]));
                check_field("last", int'(want_grant.last), int'(o_m_axis_tlast));
            end
        end
    end

    // Receiver: a forced hold-off takes priority over the rotating stall pattern.
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_len > 0) begin
                i_m_axis_tready = 1'b0;
                rx_hold_len--;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = t_rx_mode'($urandom_range(0, 2));
                    rx_mode_left = int'($urandom_range(10, 80));
                end
                rx_mode_left--;
                rx_phase++;
                case (rx_mode)
                    RX_STREAM:   i_m_axis_tready = 1'b1;
                    RX_RANDOM:   i_m_axis_tready = 1'($urandom_range(0, 1));
                    RX_PERIODIC: i_m_axis_tready = (rx_phase % 4) == 0;
                    default:     i_m_axis_tready = 1'b1;
                endcase
            end
        end
    end

    task automatic send_request(logic [1:0] op, logic [2:0] chan, logic [3:0] cnt);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = op;
        i_s_axis_tdata  = {1'b0, cnt, chan};
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        schedule_request(op, chan, cnt);
    endtask

    // Drops valid for a number of cycles, with junk on the data lines.
    task automatic pause_requests(int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            i_s_axis_tuser  = 2'($urandom_range(0, 3));
            i_s_axis_tdata  = {1'b0, 7'($urandom_range(0, 127))};
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Valid is dropped first so that the last request is not offered twice.
    task automatic wait_for_grants();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_grants.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly stages and completions sized from the model so the ring keeps turning.
    task automatic send_random_request();
        int         r;
        int         used;
        logic [1:0] op;
        logic [2:0] chan;
        logic [3:0] cnt;

        r    = int'($urandom_range(0, 99));
        chan = 3'($urandom_range(0, 7));
        if (r < 52) begin
            op = OP_STAGE;
            r  = int'($urandom_range(0, 99));
            if (r < 6)
                cnt = 4'd0;
            else if (r < 14)
                cnt = 4'($urandom_range(12, 15));
            else if (r < 60)
                cnt = 4'($urandom_range(1, 4));
            else
                cnt = 4'($urandom_range(5, 11));
        end else if (r < 86) begin
            op   = OP_COMPLETE;
            used = ring_in_use();
            if ($urandom_range(0, 3) == 0)
                cnt = 4'($urandom_range(0, 15));
            else
                cnt = 4'($urandom_range(used, 1));
        end else if (r < 95) begin
            op  = OP_ENABLE;
            cnt = 4'($urandom_range(0, 15));
        end else begin
            op  = OP_UNUSED;
            cnt = 4'($urandom_range(0, 15));
        end
        send_request(op, chan, cnt);
    endtask

    task automatic test_directed();
        send_request(OP_STAGE, 3'd0, 4'd1);
        send_request(OP_ENABLE, 3'd7, 4'd15);
        // A packet larger than any free count stays staged.
        send_request(OP_STAGE, 3'd7, 4'd12);
        send_request(OP_STAGE, 3'd3, 4'd0);
        send_request(OP_STAGE, 3'd5, 4'd10);
        send_request(OP_STAGE, 3'd2, 4'd4);
        // Channel already holds a packet, so this request is dropped.
        send_request(OP_STAGE, 3'd2, 4'd3);
        // Over-completion saturates at the slots in use.
        send_request(OP_COMPLETE, 3'd0, 4'd15);
        send_request(OP_UNUSED, 3'd7, 4'd15);
        send_request(OP_STAGE, 3'd1, 4'd15);
        send_request(OP_COMPLETE, 3'd6, 4'd0);
        send_request(OP_STAGE, 3'd4, 4'd7);
        send_request(OP_STAGE, 3'd0, 4'd1);
        send_request(OP_STAGE, 3'd3, 4'd2);
        send_request(OP_STAGE, 3'd6, 4'd1);
        send_request(OP_STAGE, 3'd5, 4'd3);
        send_request(OP_STAGE, 3'd2, 4'd2);
        // One completion releases a round-robin run of several grants.
        send_request(OP_COMPLETE, 3'd0, 4'd15);
        send_request(OP_COMPLETE, 3'd0, 4'd5);
        send_request(OP_STAGE, 3'd4, 4'd11);
        send_request(OP_ENABLE, 3'd0, 4'd0);
        send_request(OP_STAGE, 3'd6, 4'd8);
        send_request(OP_COMPLETE, 3'd0, 4'd1);
        wait_for_grants();
    endtask

    task automatic test_random_traffic();
        int burst;
        int sent;

        sent = 0;
        while (sent < 300) begin
            burst = int'($urandom_range(1, 12));
            repeat (burst) begin
                send_random_request();
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_requests(int'($urandom_range(1, 15)));
        end
    endtask

    // The receiver holds off while requests keep coming, so the block backs up.
    task automatic test_backpressure();
        send_request(OP_ENABLE, 3'd0, 4'd0);
        rx_hold_len = 300;
        repeat (40)
            send_random_request();
        wait_for_grants();
    endtask

    // Short bursts, each followed by a pause until every grant has come back.
    task automatic test_drain_pause();
        repeat (30) begin
            repeat ($urandom_range(1, 4))
                send_random_request();
            pause_requests(1);
            wait_for_grants();
            pause_requests(int'($urandom_range(0, 20)));
        end
    endtask

    initial begin
        clear_model();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_traffic();
        test_backpressure();
        test_drain_pause();

        pause_requests(1);
        wait_for_grants();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
